>>> design/tsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsm_pkg;

  localparam int DEF_MAX_ENTRIES   = 16;
  localparam int DEF_MAX_TOPIC_LEN = 32;

  localparam logic [7:0] SYM_HASH  = 8'h23;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_SLASH = 8'h2F;

  localparam logic [2:0] OP_SUBSCRIBE    = 3'd0;
  localparam logic [2:0] OP_PUBLISH      = 3'd1;
  localparam logic [2:0] OP_UNSUB_TOPIC  = 3'd2;
  localparam logic [2:0] OP_UNSUB_PROG   = 3'd3;
  localparam logic [2:0] OP_SHIFT_PROG   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [3:0] {
    C_HOLD,
    C_STEP,
    C_RESTART,
    C_LOAD,
    C_LOADREC,
    C_SWEEP,
    C_SHIFT,
    C_PROG,
    C_MARK
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_DONE,
    S_COPY,
    S_LOADREC,
    S_FIND,
    S_SWEEP,
    S_SHIFT
  } state_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] sym;
    logic       last;
    logic       mark;
    logic [7:0] prog;
    logic [7:0] func;
    logic       prov;
  } cell_ctl_t;

  typedef struct packed {
    logic [7:0] prog;
    logic [7:0] func;
    logic       prov;
    logic       dec;
    logic       res;
    logic       skip;
    logic       eq;
    logic       hit;
    logic       rm;
  } cell_rec_t;

endpackage
`default_nettype wire

>>> design/tsm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tsm_cell #(
  parameter int TOPIC_LEN = tsm_pkg::DEF_MAX_TOPIC_LEN,
  localparam int AW = $clog2(TOPIC_LEN),
  localparam int LW = $clog2(TOPIC_LEN + 1)
) (
  input  wire                 clk,
  input  wire                 rst,
  input  tsm_pkg::cell_ctl_t  ctl,
  input  wire  [LW-1:0]       idx_m,
  input  wire  [AW-1:0]       rb_addr,
  input  wire  [AW-1:0]       addr,
  input  wire                 wr_en,
  input  wire  [AW-1:0]       wr_addr,
  input  wire  [7:0]          wr_data,
  input  wire  [LW-1:0]       load_len,
  input  wire                 sel,
  input  wire                 shift_en,
  input  tsm_pkg::cell_rec_t  nb_rec,
  input  wire  [LW-1:0]       nb_s,
  input  wire  [LW-1:0]       nb_flen,
  input  wire  [7:0]          nb_rda,
  output tsm_pkg::cell_rec_t  rec,
  output logic [LW-1:0]       s,
  output logic [LW-1:0]       flen,
  output logic [7:0]          rda
);
  import tsm_pkg::*;

  logic [7:0]    mem [TOPIC_LEN];
  logic [7:0]    rdb;
  cell_rec_t     rec_next;
  logic [LW-1:0] s_next;
  logic [LW-1:0] flen_next;
  logic [AW-1:0] ra;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [LW:0]   s_p1;
  logic [LW:0]   fl_x;
  logic [LW:0]   m_x;
  logic          eq_fin;

  always_comb begin
    rec_next  = rec;
    s_next    = s;
    flen_next = flen;
    we        = 1'b0;
    waddr     = wr_addr;
    wdata     = wr_data;
    s_p1      = {1'b0, s} + 1'b1;
    fl_x      = {1'b0, flen};
    m_x       = {1'b0, idx_m};
    eq_fin    = 1'b0;
    unique case (ctl.op)
      C_HOLD: begin
      end
      C_STEP: begin
        // rda holds the filter symbol at s, rdb the one at the topic index
        if (!rec.dec) begin
          if (rec.skip) begin
            if (ctl.sym == SYM_SLASH) begin
              rec_next.skip = 1'b0;
              if ({1'b0, s} >= fl_x) begin
                rec_next.dec = 1'b1;
                rec_next.res = ctl.last;
              end else if (ctl.last) begin
                rec_next.dec = 1'b1;
                rec_next.res = 1'b0;
              end
            end else if (ctl.last) begin
              rec_next.dec = 1'b1;
              rec_next.res = 1'b0;
            end
          end else if (rda == SYM_HASH) begin
            rec_next.dec = 1'b1;
            rec_next.res = 1'b1;
          end else if (rda == SYM_PLUS) begin
            if (s_p1 >= fl_x) begin
              rec_next.dec = 1'b1;
              rec_next.res = 1'b1;
            end else begin
              // skip the separator after the plus, then the level itself
              s_next = LW'(s_p1 + 1'b1);
              if (ctl.sym == SYM_SLASH || ctl.last) begin
                rec_next.dec = 1'b1;
                rec_next.res = 1'b0;
              end else begin
                rec_next.skip = 1'b1;
              end
            end
          end else if (rda == ctl.sym) begin
            if (s_p1 >= fl_x) begin
              rec_next.dec = 1'b1;
              rec_next.res = ctl.last;
            end else if (ctl.last) begin
              rec_next.dec = 1'b1;
              rec_next.res = 1'b0;
            end else begin
              s_next = LW'(s_p1);
            end
          end else begin
            rec_next.dec = 1'b1;
            rec_next.res = 1'b0;
          end
        end
        if (m_x >= fl_x || rdb != ctl.sym) begin
          rec_next.eq = 1'b0;
        end
        eq_fin = rec_next.eq && ((m_x + 1'b1) == fl_x);
        if (ctl.last) begin
          rec_next.hit  = rec_next.res;
          rec_next.rm   = ctl.mark && (rec.prog == ctl.prog) && eq_fin;
          rec_next.dec  = 1'b0;
          rec_next.res  = 1'b0;
          rec_next.skip = 1'b0;
          rec_next.eq   = 1'b1;
          s_next        = '0;
        end
      end
      C_RESTART: begin
        rec_next.dec  = 1'b0;
        rec_next.res  = 1'b0;
        rec_next.skip = 1'b0;
        rec_next.eq   = 1'b1;
        s_next        = '0;
      end
      C_LOAD: begin
        if (sel && wr_en) begin
          we = 1'b1;
        end
      end
      C_LOADREC: begin
        if (sel) begin
          rec_next.prog = ctl.prog;
          rec_next.func = ctl.func;
          rec_next.prov = ctl.prov;
          rec_next.dec  = 1'b0;
          rec_next.res  = 1'b0;
          rec_next.skip = 1'b0;
          rec_next.eq   = 1'b1;
          rec_next.hit  = 1'b0;
          rec_next.rm   = 1'b0;
          s_next        = '0;
          flen_next     = load_len;
        end
      end
      C_SWEEP: begin
        if (shift_en && wr_en) begin
          we    = 1'b1;
          wdata = nb_rda;
        end
      end
      C_SHIFT: begin
        if (shift_en) begin
          rec_next  = nb_rec;
          s_next    = nb_s;
          flen_next = nb_flen;
        end
      end
      C_PROG: begin
        if (rec.prog > ctl.prog) begin
          rec_next.prog = rec.prog - 8'd1;
        end
      end
      C_MARK: begin
        rec_next.rm = (rec.prog == ctl.prog);
      end
      default: begin
      end
    endcase
    if (rst) begin
      ra = '0;
    end else if (ctl.op == C_SWEEP) begin
      ra = addr;
    end else begin
      ra = s_next[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '{prog: 8'd0, func: 8'd0, prov: 1'b0, dec: 1'b0, res: 1'b0,
               skip: 1'b0, eq: 1'b1, hit: 1'b0, rm: 1'b0};
      s   <= '0;
    end else begin
      rec <= rec_next;
      s   <= s_next;
    end
    flen <= flen_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rda <= mem[ra];
    rdb <= mem[rb_addr];
  end

endmodule
`default_nettype wire

>>> design/topic_subscription_matcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Subscription table with topic filter matching.
// Input words carry one topic symbol each (subscribe, publish, unsubscribe by
// topic) or a whole command (unsubscribe program, shift programs). Result
// words leave on the output channel: match records, then one done record
// with last_result set.
// A non-final symbol gives no result; each entry cell matches it against its
// own filter as it arrives. Final symbol: publish scans the cells in order,
// emits a match record for each hit and finishes with the done record;
// subscribe copies the topic into the free cell; every removed entry moves the
// cells above it down by one before the done record. Shift programs and
// rejected operations (table full, topic too long) give their done record in
// the cycle after the word is taken.
// Input is stalled during reset, while a topic end or an unsubscribe-program
// command is being worked off, or while the output register is full and
// stalled; a stalled result holds its fields.
// Reset clears the entry count, the topic length and the output valid; the
// table then reads as empty.
module topic_subscription_matcher_core #(
  parameter int MAX_ENTRIES   = tsm_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_TOPIC_LEN = tsm_pkg::DEF_MAX_TOPIC_LEN
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [2:0] operation,
  input  wire  [7:0] symbol,
  input  wire        last_symbol,
  input  wire  [7:0] program_req,
  input  wire  [7:0] function_number,
  input  wire        provide_topic,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       kind,
  output logic [1:0] status,
  output logic [7:0] match_program,
  output logic [7:0] match_function,
  output logic       match_provide_topic,
  output logic [4:0] affected_count,
  output logic       last_result
);
  import tsm_pkg::*;

  localparam int AW = $clog2(MAX_TOPIC_LEN);
  localparam int LW = $clog2(MAX_TOPIC_LEN + 1);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_t        state, state_next;
  logic [LW-1:0] length, length_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] scan, scan_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [4:0]    acnt, acnt_next;
  logic [IW-1:0] kidx, kidx_next;
  logic [7:0]    sub_prog, sub_prog_next;
  logic [7:0]    sub_func, sub_func_next;
  logic          sub_prov, sub_prov_next;
  logic [LW-1:0] sub_len, sub_len_next;

  logic [7:0]    topic_buf [MAX_TOPIC_LEN];
  logic [7:0]    buf_rd;
  logic          buf_we;

  cell_ctl_t     ctl;
  logic [AW-1:0] rb_addr;
  logic [AW-1:0] sw_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          ofree;
  logic          acc;
  logic          found;
  logic [IW-1:0] kf;

  logic          emit;
  logic          e_kind;
  logic [1:0]    e_status;
  logic [7:0]    e_prog;
  logic [7:0]    e_func;
  logic          e_prov;
  logic [4:0]    e_count;
  logic          e_last;

  cell_rec_t     recs   [MAX_ENTRIES];
  logic [LW-1:0] s_arr  [MAX_ENTRIES];
  logic [LW-1:0] fl_arr [MAX_ENTRIES];
  logic [7:0]    rd_arr [MAX_ENTRIES];

  assign ofree    = !out_valid || !out_stall;
  assign in_stall = rst || (state != S_IDLE) || !ofree;
  assign acc      = in_valid && !in_stall;

  // lowest entry still marked for removal
  always_comb begin
    found = 1'b0;
    kf    = '0;
    for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
      if (recs[k].rm && (CW'(k) < count)) begin
        found = 1'b1;
        kf    = IW'(k);
      end
    end
  end

  always_comb begin
    state_next    = state;
    length_next   = length;
    ovf_next      = ovf;
    count_next    = count;
    scan_next     = scan;
    cnt_next      = cnt;
    acnt_next     = acnt;
    kidx_next     = kidx;
    sub_prog_next = sub_prog;
    sub_func_next = sub_func;
    sub_prov_next = sub_prov;
    sub_len_next  = sub_len;
    buf_we        = 1'b0;
    ctl = '{op: C_HOLD, sym: symbol, last: last_symbol, mark: 1'b0,
            prog: program_req, func: function_number, prov: provide_topic};
    sw_addr  = cnt[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = AW'(cnt - 1'b1);
    emit     = 1'b0;
    e_kind   = KIND_DONE;
    e_status = ST_OK;
    e_prog   = 8'd0;
    e_func   = 8'd0;
    e_prov   = 1'b0;
    e_count  = 5'd0;
    e_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (operation)
            OP_SHIFT_PROG: begin
              ctl.op = C_PROG;
              emit   = 1'b1;
            end
            OP_UNSUB_PROG: begin
              ctl.op     = C_MARK;
              acnt_next  = 5'd0;
              state_next = S_FIND;
            end
            OP_SUBSCRIBE, OP_PUBLISH, OP_UNSUB_TOPIC: begin
              if (length < LW'(MAX_TOPIC_LEN)) begin
                buf_we      = 1'b1;
                ctl.op      = C_STEP;
                length_next = length + 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
              if (last_symbol) begin
                length_next = '0;
                ovf_next    = 1'b0;
                if (ovf || length >= LW'(MAX_TOPIC_LEN)) begin
                  ctl.op   = C_RESTART;
                  emit     = 1'b1;
                  e_status = ST_TOO_LONG;
                end else if (operation == OP_SUBSCRIBE) begin
                  if (count >= CW'(MAX_ENTRIES)) begin
                    emit     = 1'b1;
                    e_status = ST_TABLE_FULL;
                  end else begin
                    sub_prog_next = program_req;
                    sub_func_next = function_number;
                    sub_prov_next = provide_topic;
                    sub_len_next  = length + 1'b1;
                    cnt_next      = '0;
                    state_next    = S_COPY;
                  end
                end else if (operation == OP_PUBLISH) begin
                  scan_next  = '0;
                  acnt_next  = 5'd0;
                  state_next = S_EMIT;
                end else begin
                  ctl.mark   = 1'b1;
                  acnt_next  = 5'd0;
                  state_next = S_FIND;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (scan == count) begin
          state_next = S_DONE;
        end else if (recs[scan[IW-1:0]].hit) begin
          if (ofree) begin
            emit      = 1'b1;
            e_kind    = KIND_MATCH;
            e_prog    = recs[scan[IW-1:0]].prog;
            e_func    = recs[scan[IW-1:0]].func;
            e_prov    = recs[scan[IW-1:0]].prov;
            e_last    = 1'b0;
            acnt_next = acnt + 5'd1;
            scan_next = scan + 1'b1;
          end
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      S_DONE: begin
        if (ofree) begin
          emit       = 1'b1;
          e_count    = acnt;
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        // buffer read is registered; the cell write uses the previous address
        ctl.op = C_LOAD;
        wr_en  = (cnt != '0);
        if (cnt == sub_len) begin
          state_next = S_LOADREC;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_LOADREC: begin
        ctl.op     = C_LOADREC;
        ctl.prog   = sub_prog;
        ctl.func   = sub_func;
        ctl.prov   = sub_prov;
        count_next = count + 1'b1;
        acnt_next  = 5'd0;
        state_next = S_DONE;
      end
      S_FIND: begin
        if (found) begin
          kidx_next  = kf;
          cnt_next   = '0;
          state_next = S_SWEEP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SWEEP: begin
        // move filters down one cell above the removed entry
        ctl.op = C_SWEEP;
        wr_en  = (cnt != '0);
        if (cnt == LW'(MAX_TOPIC_LEN)) begin
          state_next = S_SHIFT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SHIFT: begin
        ctl.op     = C_SHIFT;
        count_next = count - 1'b1;
        acnt_next  = acnt + 5'd1;
        state_next = S_FIND;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    rb_addr = rst ? '0 : length_next[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      length <= '0;
      ovf    <= 1'b0;
      count  <= '0;
    end else begin
      state  <= state_next;
      length <= length_next;
      ovf    <= ovf_next;
      count  <= count_next;
    end
    scan     <= scan_next;
    cnt      <= cnt_next;
    acnt     <= acnt_next;
    kidx     <= kidx_next;
    sub_prog <= sub_prog_next;
    sub_func <= sub_func_next;
    sub_prov <= sub_prov_next;
    sub_len  <= sub_len_next;
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      topic_buf[length[AW-1:0]] <= symbol;
    end
    buf_rd <= topic_buf[cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      kind                <= e_kind;
      status              <= e_status;
      match_program       <= e_prog;
      match_function      <= e_func;
      match_provide_topic <= e_prov;
      affected_count      <= e_count;
      last_result         <= e_last;
    end
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    localparam int NB = (k < MAX_ENTRIES - 1) ? k + 1 : k;
    tsm_cell #(
      .TOPIC_LEN(MAX_TOPIC_LEN)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .idx_m    (length),
      .rb_addr  (rb_addr),
      .addr     (sw_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (buf_rd),
      .load_len (sub_len),
      .sel      (IW'(k) == count[IW-1:0]),
      .shift_en (IW'(k) >= kidx),
      .nb_rec   (recs[NB]),
      .nb_s     (s_arr[NB]),
      .nb_flen  (fl_arr[NB]),
      .nb_rda   (rd_arr[NB]),
      .rec      (recs[k]),
      .s        (s_arr[k]),
      .flen     (fl_arr[k]),
      .rda      (rd_arr[k])
    );
  end

endmodule
`default_nettype wire
